// ----- design/cchd_pkg.sv -----
// types and constants shared by the can command frame handler
package cchd_pkg;

  localparam int unsigned IdW       = 29;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned NumBytes  = 8;
  localparam int unsigned NumCmpB   = 6;
  localparam int unsigned SumW      = 11;
  localparam int unsigned CntW      = 3;
  localparam int unsigned ChkW      = 16;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned InDataW   = 96;
  localparam int unsigned OutDataW  = 80;
  localparam int unsigned KindW     = 2;

  localparam logic [CntW-1:0] MaxRepeat = 3'd3;

  localparam logic [ByteW-1:0] CharUpperA = 8'd65;
  localparam logic [ByteW-1:0] CharUpperZ = 8'd90;
  localparam logic [ByteW-1:0] CharF      = 8'h46;
  localparam logic [ByteW-1:0] CharR      = 8'h52;
  localparam logic [ByteW-1:0] CharO      = 8'h4f;
  localparam logic [ByteW-1:0] CharC      = 8'h43;
  localparam logic [ByteW-1:0] CharD      = 8'h44;
  localparam logic [ByteW-1:0] CharZero   = 8'd48;
  localparam logic [ByteW-1:0] CharThree  = 8'h33;
  localparam logic [ByteW-1:0] GpsTagA    = 8'h41;
  localparam logic [ByteW-1:0] GpsTagB    = 8'h42;

  typedef enum logic [2:0] {
    VM_IDLE,
    VM_RUNNING,
    VM_DOOR_OPEN,
    VM_DOOR_CLOSED,
    VM_DIAG,
    VM_STOP
  } vehicle_mode_e;

  typedef enum logic [KindW-1:0] {
    TX_NONE,
    TX_ACK,
    TX_TRIP
  } tx_kind_e;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_A,
    TAG_B
  } tag_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_COMMAND_ID,
    CFG_HEARTBEAT_ID,
    CFG_TRIP_ACK_ID,
    CFG_GPS_ID,
    CFG_TRIP_TX_ID
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0] command_id;
    logic [IdW-1:0] heartbeat_id;
    logic [IdW-1:0] trip_ack_id;
    logic [IdW-1:0] gps_id;
    logic [IdW-1:0] trip_tx_id;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic [IdW-1:0]   frame_id;
    logic [WordW-1:0] payload_low;
    logic [WordW-1:0] payload_high;
  } item_t;

  typedef struct packed {
    tx_kind_e         tx_kind;
    logic [WordW-1:0] tx_low;
    logic [WordW-1:0] tx_high;
    vehicle_mode_e    vehicle_mode;
    logic             running_flag;
    logic             diagnosis_flag;
    logic             status_clear;
    logic             trip_pending;
    logic             heartbeat_seen;
    tag_e             location_tag;
  } result_t;

endpackage

// ----- design/cchd_eval.sv -----
// frame evaluation logic and vehicle state registers
module cchd_eval (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cchd_pkg::cfg_t    cfg_i,
  input  cchd_pkg::item_t   item_i,
  output cchd_pkg::result_t result_o
);
  import cchd_pkg::*;

  logic [ByteW-1:0] prev_q [NumCmpB];
  logic [ByteW-1:0] prev_d [NumCmpB];
  vehicle_mode_e    vmode_q, vmode_d;
  logic             run_q, run_d;
  logic             diag_q, diag_d;
  logic             pend_q, pend_d;
  logic [ChkW-1:0]  trip_sum_q, trip_sum_d;
  tag_e             tag_q, tag_d;

  logic [ByteW-1:0] b [NumBytes];
  logic [SumW-1:0]  cmd_sum;
  logic [CntW-1:0]  same_cnt;
  logic [ChkW-1:0]  ack_sum;
  logic [ChkW-1:0]  trip_s;
  logic             is_upper, first_ok, third_ok;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      b[i]     = item_i.payload_low[ByteW*i +: ByteW];
      b[i + 4] = item_i.payload_high[ByteW*i +: ByteW];
    end
  end

  always_comb begin
    cmd_sum  = '0;
    same_cnt = '0;
    for (int i = 0; i < NumCmpB; i++) begin
      cmd_sum  = cmd_sum + SumW'(b[i]);
      same_cnt = same_cnt + CntW'(prev_q[i] == b[i]);
    end
  end

  assign ack_sum = ChkW'(cfg_i.command_id[7:0]) + ChkW'(cfg_i.command_id[15:8])
                 + ChkW'(cfg_i.command_id[23:16]) + ChkW'(cfg_i.command_id[28:24])
                 + ChkW'(cmd_sum[7:0]) + ChkW'(cmd_sum[SumW-1:8]);
  assign trip_s  = ChkW'(b[0]) + ChkW'(b[1]);

  assign is_upper = (b[0] >= CharUpperA) && (b[0] <= CharUpperZ);
  assign first_ok = (b[0] == CharF) || (b[0] == CharR) || (b[0] == CharO) || (b[0] == CharC);
  assign third_ok = (b[3] == CharF) || (b[3] == CharR) || (b[3] == CharZero);

  always_comb begin
    prev_d     = prev_q;
    vmode_d    = vmode_q;
    run_d      = run_q;
    diag_d     = diag_q;
    pend_d     = pend_q;
    trip_sum_d = trip_sum_q;
    tag_d      = tag_q;
    result_o   = '0;

    if (item_i.mode) begin
      trip_sum_d       = trip_s;
      result_o.tx_kind = TX_TRIP;
      result_o.tx_low  = {16'd0, b[1], b[0]};
      result_o.tx_high = {trip_s, 16'd0};
    end else if (item_i.frame_id == cfg_i.command_id) begin
      if (is_upper) begin
        if (first_ok && third_ok) begin
          pend_d = 1'b1;
          if (same_cnt <= MaxRepeat) begin
            if (ChkW'(cmd_sum) == {b[7], b[6]}) begin
              if ((b[0] == CharF) || (b[0] == CharR)) begin
                run_d   = 1'b1;
                vmode_d = VM_RUNNING;
              end else if (b[0] == CharO) begin
                vmode_d = VM_DOOR_OPEN;
              end else begin
                vmode_d = VM_DOOR_CLOSED;
              end
            end
            result_o.tx_kind = TX_ACK;
            result_o.tx_low  = WordW'(cfg_i.command_id);
            result_o.tx_high = {ack_sum, ChkW'(cmd_sum)};
          end
        end else if (b[0] == CharD) begin
          result_o.status_clear = 1'b1;
          vmode_d               = VM_DIAG;
          diag_d                = 1'b1;
        end
      end else if (b[0] == CharThree) begin
        vmode_d = VM_STOP;
      end
      for (int i = 0; i < NumCmpB; i++) begin
        prev_d[i] = b[i];
      end
    end else if (item_i.frame_id == cfg_i.heartbeat_id) begin
      result_o.heartbeat_seen = 1'b1;
    end else if (item_i.frame_id == cfg_i.trip_ack_id) begin
      if ((item_i.payload_low == WordW'(cfg_i.trip_tx_id)) &&
          ({b[5], b[4]} == trip_sum_q)) begin
        pend_d = 1'b0;
      end
    end else if (item_i.frame_id == cfg_i.gps_id) begin
      if (b[0] == GpsTagB) begin
        tag_d = TAG_B;
      end else if (b[0] == GpsTagA) begin
        tag_d = TAG_A;
      end
    end

    result_o.vehicle_mode   = vmode_d;
    result_o.running_flag   = run_d;
    result_o.diagnosis_flag = diag_d;
    result_o.trip_pending   = pend_d;
    result_o.location_tag   = tag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCmpB; i++) begin
        prev_q[i] <= '0;
      end
      vmode_q    <= VM_IDLE;
      run_q      <= 1'b0;
      diag_q     <= 1'b0;
      pend_q     <= 1'b0;
      trip_sum_q <= '0;
      tag_q      <= TAG_NONE;
    end else if (en_i) begin
      prev_q     <= prev_d;
      vmode_q    <= vmode_d;
      run_q      <= run_d;
      diag_q     <= diag_d;
      pend_q     <= pend_d;
      trip_sum_q <= trip_sum_d;
      tag_q      <= tag_d;
    end
  end

endmodule

// ----- design/can_command_frame_handler.sv -----
// can command frame handler top level: input register, evaluation, result register
//
//  channel  | direction | contents
//  s_axis   | in        | tuser mode; tdata frame_id, payload_low, payload_high
//  m_axis   | out       | tuser tx_kind; tdata tx bytes, vehicle state and flags
//  cfg      | in        | register index and 29-bit id value
//
// one transaction per cycle sustained while m_axis is ready; an accepted transaction passes
// the input register, then the result register, before its result can be taken.
// the evaluation logic is a single pass through the input register contents and
// the state registers.
// reset clears state, id registers and both valid flags; no clearing pass.
// a stalled m_axis holds the result while one more transaction waits in the input register.
module can_command_frame_handler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cchd_pkg::InDataW-1:0]    s_axis_tdata,  // frame_id, payload_low, payload_high
  input  logic                            s_axis_tuser,  // mode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cchd_pkg::OutDataW-1:0]   m_axis_tdata,  // tx_low, tx_high, vehicle_mode,
                                                         // running_flag, diagnosis_flag,
                                                         // status_clear, trip_pending,
                                                         // heartbeat_seen, location_tag
  output logic [cchd_pkg::KindW-1:0]      m_axis_tuser,  // tx_kind
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cchd_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [cchd_pkg::CfgDataW-1:0]   cfg_data_i
);
  import cchd_pkg::*;

  cfg_t    cfg_q;
  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t result_q;
  result_t result_d;
  logic    advance;
  logic    s_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_COMMAND_ID:   cfg_q.command_id   <= cfg_data_i[IdW-1:0];
        CFG_HEARTBEAT_ID: cfg_q.heartbeat_id <= cfg_data_i[IdW-1:0];
        CFG_TRIP_ACK_ID:  cfg_q.trip_ack_id  <= cfg_data_i[IdW-1:0];
        CFG_GPS_ID:       cfg_q.gps_id       <= cfg_data_i[IdW-1:0];
        CFG_TRIP_TX_ID:   cfg_q.trip_tx_id   <= cfg_data_i[IdW-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q.mode         <= s_axis_tuser;
      item_q.frame_id     <= s_axis_tdata[IdW-1:0];
      item_q.payload_low  <= s_axis_tdata[IdW +: WordW];
      item_q.payload_high <= s_axis_tdata[IdW+WordW +: WordW];
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  cchd_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .result_o (result_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.tx_kind;
  assign m_axis_tdata  = {6'd0,
                          result_q.location_tag,
                          result_q.heartbeat_seen,
                          result_q.trip_pending,
                          result_q.status_clear,
                          result_q.diagnosis_flag,
                          result_q.running_flag,
                          result_q.vehicle_mode,
                          result_q.tx_high,
                          result_q.tx_low};

endmodule

// ----- dv/can_command_frame_handler_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the can command frame handler, streaming in and out
module can_command_frame_handler_tb;
  import cchd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct = 21;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned NumPhases = 6;
  localparam logic [IdW-1:0] IdMax = '1;

  typedef struct {
    logic           mode;
    logic [IdW-1:0] frame_id;
    logic [WordW-1:0] lo;
    logic [WordW-1:0] hi;
    bit             typed;
    result_t        res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor copy of id registers and vehicle state
  logic [IdW-1:0] cmd_id_q, hb_id_q, tack_id_q, gps_id_q, ttx_id_q;
  logic [ByteW-1:0] prev_bytes_q [NumCmpB];
  vehicle_mode_e vm_q;
  logic run_q, diag_q, pend_q;
  logic [15:0] trip_sum_q;
  tag_e tag_q;

  result_t frame_results_q [$];
  stim_row_t stim_rows [$];
  int unsigned idle_pct = IdlePct;
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_acks = 0;
  int unsigned n_trips = 0;
  int unsigned cycles = 0;

  can_command_frame_handler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic result_t predict_frame(input logic mode, input logic [IdW-1:0] fid,
                                            input logic [WordW-1:0] lo,
                                            input logic [WordW-1:0] hi);
    result_t r;
    logic [ByteW-1:0] b [NumBytes];
    logic [15:0] s;
    logic [15:0] acks;
    logic [CntW-1:0] same;
    int i;
    r = '0;
    for (i = 0; i < 4; i++) begin
      b[i] = lo[8*i +: 8];
      b[i+4] = hi[8*i +: 8];
    end
    if (mode) begin
      s = 16'(b[0]) + 16'(b[1]);
      trip_sum_q = s;
      r.tx_kind = TX_TRIP;
      r.tx_low = {16'h0, b[1], b[0]};
      r.tx_high = {s, 16'h0};
    end else if (fid == cmd_id_q) begin
      if (b[0] >= CharUpperA && b[0] <= CharUpperZ) begin
        if ((b[0] == CharF || b[0] == CharR || b[0] == CharO || b[0] == CharC) &&
            (b[3] == CharF || b[3] == CharR || b[3] == CharZero)) begin
          pend_q = 1'b1;
          s = '0;
          same = '0;
          for (i = 0; i < NumCmpB; i++) begin
            s = s + 16'(b[i]);
            if (prev_bytes_q[i] == b[i]) same = same + 1'b1;
          end
          if (same <= MaxRepeat) begin
            if (s == {b[7], b[6]}) begin
              if (b[0] == CharF || b[0] == CharR) begin
                run_q = 1'b1;
                vm_q = VM_RUNNING;
              end else if (b[0] == CharO) begin
                vm_q = VM_DOOR_OPEN;
              end else begin
                vm_q = VM_DOOR_CLOSED;
              end
            end
            acks = 16'(cmd_id_q[7:0]) + 16'(cmd_id_q[15:8]) + 16'(cmd_id_q[23:16])
                 + 16'(cmd_id_q[28:24]) + 16'(s[7:0]) + 16'(s[15:8]);
            r.tx_kind = TX_ACK;
            r.tx_low = {3'b0, cmd_id_q};
            r.tx_high = {acks, s};
          end
        end else if (b[0] == CharD) begin
          r.status_clear = 1'b1;
          vm_q = VM_DIAG;
          diag_q = 1'b1;
        end
      end else if (b[0] == CharThree) begin
        vm_q = VM_STOP;
      end
      for (i = 0; i < NumCmpB; i++) prev_bytes_q[i] = b[i];
    end else if (fid == hb_id_q) begin
      r.heartbeat_seen = 1'b1;
    end else if (fid == tack_id_q) begin
      if (lo == {3'b0, ttx_id_q} && {b[5], b[4]} == trip_sum_q) pend_q = 1'b0;
    end else if (fid == gps_id_q) begin
      if (b[0] == GpsTagB) tag_q = TAG_B;
      else if (b[0] == GpsTagA) tag_q = TAG_A;
    end
    r.vehicle_mode = vm_q;
    r.running_flag = run_q;
    r.diagnosis_flag = diag_q;
    r.trip_pending = pend_q;
    r.location_tag = tag_q;
    return r;
  endfunction

  // random item, mostly frames aimed at the configured ids with plausible content
  task automatic gen_item(output logic mode, output logic [IdW-1:0] fid,
                          output logic [WordW-1:0] lo, output logic [WordW-1:0] hi);
    logic [ByteW-1:0] b [NumBytes];
    logic [15:0] s;
    int pick;
    int i;
    mode = 1'b0;
    fid = IdW'($urandom);
    for (i = 0; i < NumBytes; i++) b[i] = ByteW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      mode = 1'b1;
    end else if (pick < 58) begin
      fid = cmd_id_q;
      case ($urandom_range(0, 7))
        0: b[0] = CharF;
        1: b[0] = CharR;
        2: b[0] = CharO;
        3: b[0] = CharC;
        4: b[0] = CharD;
        5: b[0] = CharThree;
        default: ;
      endcase
      case ($urandom_range(0, 4))
        0: b[3] = CharF;
        1: b[3] = CharR;
        2: b[3] = CharZero;
        default: ;
      endcase
      for (i = 0; i < NumCmpB; i++)
        if ($urandom_range(0, 1) == 0) b[i] = prev_bytes_q[i];
      if ($urandom_range(0, 9) < 7) begin
        s = '0;
        for (i = 0; i < NumCmpB; i++) s = s + 16'(b[i]);
        {b[7], b[6]} = s;
      end
    end else if (pick < 66) begin
      fid = hb_id_q;
    end else if (pick < 80) begin
      fid = tack_id_q;
      if ($urandom_range(0, 3) != 0) {b[3], b[2], b[1], b[0]} = {3'b0, ttx_id_q};
      if ($urandom_range(0, 3) != 0) {b[5], b[4]} = trip_sum_q;
    end else if (pick < 90) begin
      fid = gps_id_q;
      case ($urandom_range(0, 2))
        0: b[0] = GpsTagA;
        1: b[0] = GpsTagB;
        default: ;
      endcase
    end
    lo = {b[3], b[2], b[1], b[0]};
    hi = {b[7], b[6], b[5], b[4]};
  endtask

  task automatic send_item(input logic mode, input logic [IdW-1:0] fid,
                           input logic [WordW-1:0] lo, input logic [WordW-1:0] hi,
                           input bit typed, input result_t typed_res);
    result_t want;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {3'b0, hi, lo, fid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = predict_frame(mode, fid, lo, hi);
    frame_results_q.push_back(typed ? typed_res : want);
    n_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // writes all id registers, upper data bits random, plus one unused index
  task automatic set_ids(input logic [IdW-1:0] c, input logic [IdW-1:0] h,
                         input logic [IdW-1:0] t, input logic [IdW-1:0] g,
                         input logic [IdW-1:0] x);
    logic [IdW-1:0] ids [5];
    logic [CfgAddrW-1:0] addr;
    int i;
    ids = '{c, h, t, g, x};
    for (i = 0; i < 6; i++) begin
      if (i < 5) addr = CfgAddrW'(i);
      else addr = CfgAddrW'(CFG_TRIP_TX_ID) + CfgAddrW'($urandom_range(1, 3));
      cfg_valid_i <= 1'b1;
      cfg_addr_i <= addr;
      cfg_data_i <= {3'($urandom), (i < 5) ? ids[i] : IdW'($urandom)};
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (addr)
        CFG_COMMAND_ID:   cmd_id_q = ids[i];
        CFG_HEARTBEAT_ID: hb_id_q = ids[i];
        CFG_TRIP_ACK_ID:  tack_id_q = ids[i];
        CFG_GPS_ID:       gps_id_q = ids[i];
        CFG_TRIP_TX_ID:   ttx_id_q = ids[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void add_row(input logic mode, input logic [IdW-1:0] fid,
                                  input logic [WordW-1:0] lo, input logic [WordW-1:0] hi,
                                  input bit typed, input result_t res);
    stim_row_t row;
    row.mode = mode;
    row.frame_id = fid;
    row.lo = lo;
    row.hi = hi;
    row.typed = typed;
    row.res = res;
    stim_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result();
    result_t got;
    result_t want;
    got.tx_kind = tx_kind_e'(m_axis_tuser);
    got.tx_low = m_axis_tdata[31:0];
    got.tx_high = m_axis_tdata[63:32];
    got.vehicle_mode = vehicle_mode_e'(m_axis_tdata[66:64]);
    got.running_flag = m_axis_tdata[67];
    got.diagnosis_flag = m_axis_tdata[68];
    got.status_clear = m_axis_tdata[69];
    got.trip_pending = m_axis_tdata[70];
    got.heartbeat_seen = m_axis_tdata[71];
    got.location_tag = tag_e'(m_axis_tdata[73:72]);
    n_results++;
    if (frame_results_q.size() == 0) begin
      $error("result transaction with nothing expected");
      errors++;
    end else begin
      want = frame_results_q.pop_front();
      if (want.tx_kind == TX_ACK) n_acks++;
      if (want.tx_kind == TX_TRIP) n_trips++;
      check_field("tx_kind", want.tx_kind, got.tx_kind);
      check_field("tx_low", want.tx_low, got.tx_low);
      check_field("tx_high", want.tx_high, got.tx_high);
      check_field("vehicle_mode", want.vehicle_mode, got.vehicle_mode);
      check_field("running_flag", want.running_flag, got.running_flag);
      check_field("diagnosis_flag", want.diagnosis_flag, got.diagnosis_flag);
      check_field("status_clear", want.status_clear, got.status_clear);
      check_field("trip_pending", want.trip_pending, got.trip_pending);
      check_field("heartbeat_seen", want.heartbeat_seen, got.heartbeat_seen);
      check_field("location_tag", want.location_tag, got.location_tag);
    end
  endtask

  // result side, with one long hold-off once traffic is flowing
  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_results >= 500) begin
        hold_done = 1'b1;
        hold_left = 60;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  initial begin
    logic mode;
    logic [IdW-1:0] fid;
    logic [WordW-1:0] lo, hi;
    int ph, n;
    cmd_id_q = '0;
    hb_id_q = '0;
    tack_id_q = '0;
    gps_id_q = '0;
    ttx_id_q = '0;
    foreach (prev_bytes_q[k]) prev_bytes_q[k] = '0;
    vm_q = VM_IDLE;
    run_q = 1'b0;
    diag_q = 1'b0;
    pend_q = 1'b0;
    trip_sum_q = '0;
    tag_q = TAG_NONE;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_ids(29'h123, 29'h456, 29'h789, IdMax, 29'h0ABCDEF);
    add_row(1'b0, '0, '1, '1, 1'b1,
            result_t'{TX_NONE, 32'h0, 32'h0, VM_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, TAG_NONE});
    add_row(1'b1, 29'h456, '1, '1, 1'b1,
            result_t'{TX_TRIP, 32'h0000ffff, 32'h01fe0000, VM_IDLE,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, TAG_NONE});
    add_row(1'b0, 29'h456, '0, '0, 1'b1,
            result_t'{TX_NONE, 32'h0, 32'h0, VM_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, TAG_NONE});
    add_row(1'b0, IdMax, 32'h00000041, '0, 1'b0, '0);
    add_row(1'b0, IdMax, 32'hffffff42, '1, 1'b0, '0);
    add_row(1'b0, IdMax, 32'h00000043, '0, 1'b0, '0);
    // F with matching sum, R repeating five bytes, O with a bad sum, C with a zero code
    add_row(1'b0, 29'h123, 32'h46020146, 32'h00960403, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h46020152, 32'h00000403, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h5220104f, 32'h00005040, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h30221143, 32'h011d4433, 1'b0, '0);
    // letter range edges, uppercase letters outside the command set, D, 3 and a lowercase letter
    add_row(1'b0, 29'h123, 32'h46000040, '0, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h46000041, '0, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h4600005b, '0, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h4600005a, '0, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h58000046, '0, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h00000044, '0, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h00000033, '0, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h46000061, '0, 1'b0, '0);
    // trip status, wrong acknowledge, matching acknowledge
    add_row(1'b1, '0, 32'h00003412, '0, 1'b0, '0);
    add_row(1'b0, 29'h789, 32'h00abcdef, 32'h00000047, 1'b0, '0);
    add_row(1'b0, 29'h789, 32'h00abcdef, 32'h00000046, 1'b0, '0);
    add_row(1'b0, 29'h123, 32'h52ffff52, 32'h04a0ffff, 1'b0, '0);
    add_row(1'b1, IdMax, '0, '1, 1'b0, '0);
    add_row(1'b0, 29'h1ffffffe, 32'h5a5aa5a5, 32'hc33c3cc3, 1'b0, '0);
    foreach (stim_rows[r])
      send_item(stim_rows[r].mode, stim_rows[r].frame_id, stim_rows[r].lo,
                stim_rows[r].hi, stim_rows[r].typed, stim_rows[r].res);
    drain_results();

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: set_ids('0, '0, '0, '0, '0);
        2: set_ids(IdMax, '0, IdMax - 1'b1, 29'h1, IdMax);
        3: begin
          fid = IdW'($urandom);
          set_ids(IdW'($urandom), fid, fid, fid, IdW'($urandom));
        end
        default: set_ids(IdW'($urandom), IdW'($urandom), IdW'($urandom),
                         IdW'($urandom), IdW'($urandom));
      endcase
      idle_pct = (ph == NumPhases - 1) ? 0 : IdlePct;
      for (n = 0; n < PhaseItems; n++) begin
        gen_item(mode, fid, lo, hi);
        send_item(mode, fid, lo, hi, 1'b0, '0);
        if (ph == 3 && n == PhaseItems / 2) drain_results();
      end
      drain_results();
    end
    idle_pct = IdlePct;
    repeat (10) @(posedge clk_i);

    $display("sent %0d transactions over %0d id settings, %0d results checked",
             n_sent, NumPhases + 1, n_results);
    $display("%0d ack frames and %0d trip status frames among them", n_acks, n_trips);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
